// File: design/assert_macros.svh
// Assertion shorthands used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational check sampled at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/tdpr_pkg.sv
package tdpr_pkg;

	localparam int DIGIT_COUNT = 4;
	localparam logic [9:0] DUTY_MAX = 10'd1023;

	typedef enum logic [2:0] {
		REG_REFRESH_PERIOD = 3'd0,
		REG_MUX_PERIOD     = 3'd1,
		REG_RATE_PERIOD    = 3'd2,
		REG_RATE_SCALE     = 3'd3,
		REG_RAMP_STEP      = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [7:0] refresh_period;
		logic [7:0] mux_period;
		logic [7:0] rate_period;
		logic [7:0] rate_scale;
		logic [9:0] ramp_step;
	} cfg_t;

	localparam logic [7:0] RST_REFRESH_PERIOD = 8'd200;
	localparam logic [7:0] RST_MUX_PERIOD     = 8'd10;
	localparam logic [7:0] RST_RATE_PERIOD    = 8'd10;
	localparam logic [7:0] RST_RATE_SCALE     = 8'd200;
	localparam logic [9:0] RST_RAMP_STEP      = 10'd10;

	// digit 0 is units, digit 3 thousands
	typedef logic [DIGIT_COUNT-1:0][3:0] digits_t;

	// load strobes for the precompute stages
	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} split_ctl_t;

	// segment a in bit 0 through segment g in bit 6; codes above 9 are blank
	function automatic logic [6:0] seg_pattern(input logic [3:0] code);
		logic [6:0] pat;
		case (code)
			4'd0: pat = 7'b0111111;
			4'd1: pat = 7'b0000110;
			4'd2: pat = 7'b1011011;
			4'd3: pat = 7'b1001111;
			4'd4: pat = 7'b1100110;
			4'd5: pat = 7'b1101101;
			4'd6: pat = 7'b1111101;
			4'd7: pat = 7'b0000111;
			4'd8: pat = 7'b1111111;
			4'd9: pat = 7'b1100111;
			default: pat = 7'b0000000;
		endcase
		return pat;
	endfunction

endpackage

// File: design/tdpr_cfg.sv
module tdpr_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [2:0]       wr_index,
	input  logic [9:0]       wr_data,
	output tdpr_pkg::cfg_t   cfg
);

	tdpr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.refresh_period <= tdpr_pkg::RST_REFRESH_PERIOD;
			cfg_q.mux_period     <= tdpr_pkg::RST_MUX_PERIOD;
			cfg_q.rate_period    <= tdpr_pkg::RST_RATE_PERIOD;
			cfg_q.rate_scale     <= tdpr_pkg::RST_RATE_SCALE;
			cfg_q.ramp_step      <= tdpr_pkg::RST_RAMP_STEP;
		end else if (wr_en) begin
			case (wr_index)
				tdpr_pkg::REG_REFRESH_PERIOD: cfg_q.refresh_period <= wr_data[7:0];
				tdpr_pkg::REG_MUX_PERIOD:     cfg_q.mux_period     <= wr_data[7:0];
				tdpr_pkg::REG_RATE_PERIOD:    cfg_q.rate_period    <= wr_data[7:0];
				tdpr_pkg::REG_RATE_SCALE:     cfg_q.rate_scale     <= wr_data[7:0];
				tdpr_pkg::REG_RAMP_STEP:      cfg_q.ramp_step      <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/tdpr_split.sv
// Stateless precompute: decimal digits of the display sample and the
// scaled ramp period, two register stages.
module tdpr_split #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                      clk,
	input  tdpr_pkg::split_ctl_t      ctl,
	input  logic [SAMPLE_BITS-1:0]    display_s1,
	input  logic [SAMPLE_BITS-1:0]    rate_s1,
	input  logic                      button_s1,
	input  logic [7:0]                rate_scale,
	output tdpr_pkg::digits_t         digits_s3,
	output logic [7:0]                period_s3,
	output logic                      button_s3
);

	localparam int THOUSANDS_MAX = ((1 << SAMPLE_BITS) - 1) / 1000;
	localparam int PROD_BITS = SAMPLE_BITS + 8;
	localparam logic [SAMPLE_BITS:0] FULL_SCALE = (SAMPLE_BITS + 1)'((1 << SAMPLE_BITS) - 1);
	localparam logic [SAMPLE_BITS:0] FULL_SCALE_X2 = (SAMPLE_BITS + 1)'(2 * ((1 << SAMPLE_BITS) - 1));

	logic [3:0]           thou;
	logic [9:0]           rem1;
	logic [3:0]           thou_s2;
	logic [9:0]           rem1_s2;
	logic [PROD_BITS-1:0] prod_s2;
	logic                 button_s2;

	logic [3:0]           hund, tens;
	logic [6:0]           rem2;
	logic [3:0]           rem3;
	logic [7:0]           q_est;
	logic [SAMPLE_BITS:0] q_rem;
	logic [7:0]           period;

	// stage 1 -> 2: thousands by compare-and-select, sample times scale
	always_comb begin
		thou = '0;
		rem1 = 10'(display_s1);
		for (int k = 1; k <= THOUSANDS_MAX; k++) begin
			if (display_s1 >= SAMPLE_BITS'(k * 1000)) begin
				thou = 4'(k);
				rem1 = 10'(display_s1 - SAMPLE_BITS'(k * 1000));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			thou_s2   <= thou;
			rem1_s2   <= rem1;
			prod_s2   <= PROD_BITS'(rate_s1) * PROD_BITS'(rate_scale);
			button_s2 <= button_s1;
		end
	end

	// stage 2 -> 3: hundreds, tens, units; divide by 2^N-1 as shift plus fix-up
	always_comb begin
		hund = '0;
		rem2 = 7'(rem1_s2);
		for (int k = 1; k <= 9; k++) begin
			if (rem1_s2 >= 10'(k * 100)) begin
				hund = 4'(k);
				rem2 = 7'(rem1_s2 - 10'(k * 100));
			end
		end
		tens = '0;
		rem3 = 4'(rem2);
		for (int k = 1; k <= 9; k++) begin
			if (rem2 >= 7'(k * 10)) begin
				tens = 4'(k);
				rem3 = 4'(rem2 - 7'(k * 10));
			end
		end
		// x = q*2^N + lo  ->  x = q*(2^N-1) + (lo + q)
		q_est = prod_s2[PROD_BITS-1:SAMPLE_BITS];
		q_rem = (SAMPLE_BITS + 1)'(prod_s2[SAMPLE_BITS-1:0]) + (SAMPLE_BITS + 1)'(q_est);
		if (q_rem >= FULL_SCALE_X2)
			period = q_est + 8'd2;
		else if (q_rem >= FULL_SCALE)
			period = q_est + 8'd1;
		else
			period = q_est;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			digits_s3[3] <= thou_s2;
			digits_s3[2] <= hund;
			digits_s3[1] <= tens;
			digits_s3[0] <= rem3;
			period_s3    <= period;
			button_s3    <= button_s2;
		end
	end

endmodule

// File: design/tdpr_core.sv
// Tick dividers, digit scan and duty ramp; state advances once per item.
module tdpr_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick,
	input  tdpr_pkg::cfg_t     cfg,
	input  tdpr_pkg::digits_t  digits_in,
	input  logic [7:0]         period_in,
	input  logic               button,
	output logic [6:0]         segments,
	output logic [3:0]         digit_enable,
	output logic [9:0]         duty,
	output logic               ramp_enabled
);

	logic [7:0]        refresh_cnt_q, mux_cnt_q, rate_cnt_q, ramp_cnt_q, period_q;
	logic [7:0]        refresh_cnt_d, mux_cnt_d, rate_cnt_d, ramp_cnt_d, period_d;
	tdpr_pkg::digits_t digits_q, digits_d;
	logic [1:0]        mux_index_q, mux_index_d;
	logic              button_prev_q, button_prev_d;
	logic              ramp_on_q, ramp_on_d;
	logic [9:0]        duty_q, duty_d;
	logic [6:0]        seg_q, seg_d;
	logic [3:0]        dig_q, dig_d;
	logic              refresh_fire, mux_fire, rate_fire, ramp_fire;
	logic [10:0]       duty_sum;

	always_comb begin
		refresh_fire  = refresh_cnt_q >= cfg.refresh_period;
		refresh_cnt_d = refresh_fire ? 8'd1 : refresh_cnt_q + 8'd1;
		digits_d      = refresh_fire ? digits_in : digits_q;

		mux_fire    = mux_cnt_q >= cfg.mux_period;
		mux_cnt_d   = mux_fire ? 8'd1 : mux_cnt_q + 8'd1;
		seg_d       = mux_fire ? tdpr_pkg::seg_pattern(digits_d[mux_index_q]) : seg_q;
		dig_d       = mux_fire ? 4'b0001 << mux_index_q : dig_q;
		mux_index_d = mux_fire ? mux_index_q + 2'd1 : mux_index_q;

		rate_fire  = rate_cnt_q >= cfg.rate_period;
		rate_cnt_d = rate_fire ? 8'd1 : rate_cnt_q + 8'd1;
		period_d   = rate_fire ? period_in : period_q;

		// ramp divider sees the period updated in this same tick
		ramp_fire  = ramp_cnt_q >= period_d;
		ramp_cnt_d = ramp_fire ? 8'd1 : ramp_cnt_q + 8'd1;

		ramp_on_d     = ramp_on_q;
		duty_d        = duty_q;
		button_prev_d = button_prev_q;
		duty_sum      = '0;
		if (ramp_fire) begin
			if (!button && button_prev_q) begin
				ramp_on_d = !ramp_on_q;
				duty_d    = '0;
			end
			button_prev_d = button;
			if (ramp_on_d) begin
				duty_sum = {1'b0, duty_d} + {1'b0, cfg.ramp_step};
				duty_d   = (duty_sum > {1'b0, tdpr_pkg::DUTY_MAX}) ?
					tdpr_pkg::DUTY_MAX : duty_sum[9:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_cnt_q <= 8'd1;
			mux_cnt_q     <= 8'd1;
			rate_cnt_q    <= 8'd1;
			ramp_cnt_q    <= 8'd1;
			period_q      <= 8'd1;
			digits_q      <= '0;
			mux_index_q   <= '0;
			button_prev_q <= 1'b1;
			ramp_on_q     <= 1'b0;
			duty_q        <= '0;
			seg_q         <= '0;
			dig_q         <= '0;
		end else if (tick) begin
			refresh_cnt_q <= refresh_cnt_d;
			mux_cnt_q     <= mux_cnt_d;
			rate_cnt_q    <= rate_cnt_d;
			ramp_cnt_q    <= ramp_cnt_d;
			period_q      <= period_d;
			digits_q      <= digits_d;
			mux_index_q   <= mux_index_d;
			button_prev_q <= button_prev_d;
			ramp_on_q     <= ramp_on_d;
			duty_q        <= duty_d;
			seg_q         <= seg_d;
			dig_q         <= dig_d;
		end
	end

	assign segments     = seg_q;
	assign digit_enable = dig_q;
	assign duty         = duty_q;
	assign ramp_enabled = ramp_on_q;

endmodule

// File: design/tick_display_and_pwm_ramp.sv
// Timer-tick display scanner and PWM duty ramp. Each input item is one tick
// carrying the display sample, the rate sample and the button level; each
// tick yields exactly one result item holding the segment pattern, the
// one-hot digit drive, the duty value and the ramp enable as they stand
// after that tick. One item is taken per clock while the result side does
// not stall; an item passes the input register, two precompute stages for
// the decimal split and the ramp-period scaling, then the state update whose
// registers are the result. Back-pressure on the result side stalls the
// stages behind it only as far as they are full. Configuration writes are
// taken at any time (cfg_ready is always high) and belong in idle periods.
`include "assert_macros.svh"

module tick_display_and_pwm_ramp #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// display_sample, rate_sample, button_level (zero filled to bytes)
	input  logic [((2*SAMPLE_BITS+1+7)/8)*8-1:0]   s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// segments[6:0], digit_enable[10:7], duty[20:11], ramp_enabled[21]
	output logic [23:0]                            m_tdata,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [2:0]                             cfg_index,
	input  logic [9:0]                             cfg_data
);

	tdpr_pkg::cfg_t       cfg;
	tdpr_pkg::split_ctl_t split_ctl;
	tdpr_pkg::digits_t    digits_s3;
	logic [7:0]           period_s3;
	logic                 button_s3;

	logic                   v_s1, v_s2, v_s3, out_valid_q;
	logic                   core_ok, ready_s3, ready_s2, ready_s1;
	logic [SAMPLE_BITS-1:0] display_s1, rate_s1;
	logic                   button_s1;
	logic [6:0]             segments;
	logic [3:0]             digit_enable;
	logic [9:0]             duty;
	logic                   ramp_enabled;

	assign core_ok  = !out_valid_q || m_tready;
	assign ready_s3 = !v_s3 || core_ok;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign s_tready = ready_s1;

	assign split_ctl.load_s2 = v_s1 && ready_s2;
	assign split_ctl.load_s3 = v_s2 && ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1)
				v_s1 <= s_tvalid;
			if (ready_s2)
				v_s2 <= v_s1;
			if (ready_s3)
				v_s3 <= v_s2;
			if (core_ok)
				out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && ready_s1) begin
			display_s1 <= s_tdata[SAMPLE_BITS-1:0];
			rate_s1    <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
			button_s1  <= s_tdata[2*SAMPLE_BITS];
		end
	end

	tdpr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	tdpr_split #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_split (
		.clk        (clk),
		.ctl        (split_ctl),
		.display_s1 (display_s1),
		.rate_s1    (rate_s1),
		.button_s1  (button_s1),
		.rate_scale (cfg.rate_scale),
		.digits_s3  (digits_s3),
		.period_s3  (period_s3),
		.button_s3  (button_s3)
	);

	tdpr_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (v_s3 && core_ok),
		.cfg          (cfg),
		.digits_in    (digits_s3),
		.period_in    (period_s3),
		.button       (button_s3),
		.segments     (segments),
		.digit_enable (digit_enable),
		.duty         (duty),
		.ramp_enabled (ramp_enabled)
	);

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {2'b00, ramp_enabled, duty, digit_enable, segments};

	// duty only moves away from zero while the ramp runs
	`ASSERT_IMPLIES(a_duty_idle_zero, clk, arst_n, !ramp_enabled, duty == 10'd0, "duty nonzero while ramp off")
	// while the ramp stays on the duty never falls
	`ASSERT_IMPLIES(a_duty_rises, clk, arst_n, ramp_enabled && $past(ramp_enabled), duty >= $past(duty), "duty fell during ramp")
	// a stalled last stage keeps its item
	`ASSERT_NEXT(a_s3_held, clk, arst_n, v_s3 && !core_ok, v_s3, "stage 3 item dropped under stall")
	// digit drive is never more than one digit
	`ASSERT_ALWAYS(a_digit_onehot, clk, arst_n, $onehot0(digit_enable), "more than one digit driven")

endmodule
